// ===== design/lpbu_pkg.sv =====
// ----------------------------------------------------------------------------
// lpbu_pkg
// Shared types and constants for the length-prefixed bit unpacker.
// ----------------------------------------------------------------------------
package lpbu_pkg;

  // length header size in bytes, big-endian
  localparam int unsigned HEADER_BYTES = 8;

  // operation codes
  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  // finish status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_HDR_SHORT = 2'd1;
  localparam logic [1:0] ST_MISMATCH = 2'd2;

  // largest number of bits one append may carry
  localparam logic [6:0] MAX_BITS = 7'd64;

  // classified item passed from front to back through the queue
  typedef struct packed {
    logic        finish;   // finish and report status
    logic [63:0] bits;     // bits left-aligned, first bit in bit 63
    logic [6:0]  count;    // number of valid bits, 0..64
  } entry_t;

endpackage

// ===== design/lpbu_front.sv =====
// ----------------------------------------------------------------------------
// lpbu_front
// Classifies an incoming transaction: clamps the bit count and left-aligns
// the bits so the back end can consume them from the top.
// ----------------------------------------------------------------------------
module lpbu_front (
  input  logic               operation,
  input  logic [63:0]        bit_value,
  input  logic [6:0]         bit_count,
  output lpbu_pkg::entry_t   entry
);

  logic [6:0] count_clamped;
  logic [6:0] align_shift;

  // clamp oversized counts to a full word
  assign count_clamped = (bit_count > lpbu_pkg::MAX_BITS) ? lpbu_pkg::MAX_BITS : bit_count;
  assign align_shift   = lpbu_pkg::MAX_BITS - count_clamped;

  // build queue entry, first bit to send ends up in bit 63
  always_comb begin
    entry.finish = (operation == lpbu_pkg::OP_FINISH);
    entry.count  = count_clamped;
    entry.bits   = bit_value << align_shift;
  end

endmodule

// ===== design/lpbu_fifo.sv =====
// ----------------------------------------------------------------------------
// lpbu_fifo
// Two-entry queue between the front and the back end.
// ----------------------------------------------------------------------------
module lpbu_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  lpbu_pkg::entry_t   push_entry,
  output logic               full,
  input  logic               pop,
  output logic               head_valid,
  output lpbu_pkg::entry_t   head_entry
);

  lpbu_pkg::entry_t slots [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       fill;

  assign full       = (fill == 2'd2);
  assign head_valid = (fill != 2'd0);
  assign head_entry = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ===== design/lpbu_back.sv =====
// ----------------------------------------------------------------------------
// lpbu_back
// Consumes queued items one byte per cycle while the result side does not
// stall: assembles the length header, emits payload bytes and closes every
// item with a status result.
module lpbu_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               head_valid,
  input  lpbu_pkg::entry_t   head_entry,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_byte,
  output logic               out_byte_valid,
  output logic               out_last,
  output logic [1:0]         out_status,
  output logic               out_size_known,
  output logic [63:0]        out_expected,
  output logic [63:0]        out_written
);

  // current item
  logic        busy;
  logic        is_finish;
  logic [63:0] aligned;
  logic [6:0]  remaining;

  // stream state
  logic [6:0]  partial;
  logic [2:0]  held;
  logic [3:0]  hdr_seen;
  logic [63:0] length_word;
  logic        length_ready;
  logic [63:0] emitted;

  logic        can_step;
  logic        stream_done;
  logic [7:0]  fill_sum;
  logic [14:0] join_word;
  logic [3:0]  take_bits;
  logic [3:0]  absorb_shift;
  logic [14:0] absorbed;
  logic [14:0] cur_word;
  logic [7:0]  cur_byte;
  logic [3:0]  hdr_seen_next;
  logic [63:0] emitted_next;
  logic [1:0]  finish_status;

  assign can_step    = !out_valid || out_ready;
  assign pop         = !busy && head_valid;
  assign stream_done = length_ready && (emitted >= length_word);

  // byte assembly datapath
  assign fill_sum      = {1'b0, remaining} + {5'd0, held};
  assign join_word     = {partial, aligned[63:56]};
  assign take_bits     = 4'd8 - {1'b0, held};
  assign absorb_shift  = 4'd8 - remaining[3:0];
  assign absorbed      = join_word >> absorb_shift;
  assign cur_word      = join_word >> held;
  assign cur_byte      = cur_word[7:0];
  assign hdr_seen_next = hdr_seen + 4'd1;
  assign emitted_next  = emitted + 64'd1;

  // finish status
  always_comb begin
    if (!length_ready) begin
      finish_status = lpbu_pkg::ST_HDR_SHORT;
    end else if (emitted != length_word) begin
      finish_status = lpbu_pkg::ST_MISMATCH;
    end else begin
      finish_status = lpbu_pkg::ST_OK;
    end
  end

  // item load and stepping control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      partial      <= 7'd0;
      held         <= 3'd0;
      hdr_seen     <= 4'd0;
      length_word  <= 64'd0;
      length_ready <= 1'b0;
      emitted      <= 64'd0;
      out_valid    <= 1'b0;
    end else begin
      // while busy every step below sets the output valid itself
      if (out_valid && out_ready && !busy) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        busy      <= 1'b1;
        is_finish <= head_entry.finish;
        aligned   <= head_entry.bits;
        remaining <= head_entry.count;
      end else if (busy && can_step) begin
        if (is_finish) begin
          // closing result with status
          busy           <= 1'b0;
          out_valid      <= 1'b1;
          out_byte       <= 8'd0;
          out_byte_valid <= 1'b0;
          out_last       <= 1'b1;
          out_status     <= finish_status;
          out_size_known <= length_ready;
          out_expected   <= length_word;
          out_written    <= emitted;
        end else if (stream_done || fill_sum < 8'd8) begin
          // leftover bits go into the partial byte unless the stream is done, then close
          if (!stream_done) begin
            partial <= absorbed[6:0];
            held    <= fill_sum[2:0];
          end
          busy           <= 1'b0;
          out_valid      <= 1'b1;
          out_byte       <= 8'd0;
          out_byte_valid <= 1'b0;
          out_last       <= 1'b1;
          out_status     <= lpbu_pkg::ST_OK;
          out_size_known <= length_ready;
          out_expected   <= length_word;
          out_written    <= emitted;
        end else begin
          // one complete byte
          partial   <= 7'd0;
          held      <= 3'd0;
          aligned   <= aligned << take_bits;
          remaining <= remaining - {3'd0, take_bits};
          if (!length_ready) begin
            // header byte, no result
            out_valid   <= 1'b0;
            length_word <= {length_word[55:0], cur_byte};
            hdr_seen    <= hdr_seen_next;
            if (hdr_seen_next >= 4'(lpbu_pkg::HEADER_BYTES)) begin
              length_ready <= 1'b1;
            end
          end else begin
            emitted        <= emitted_next;
            out_valid      <= 1'b1;
            out_byte       <= cur_byte;
            out_byte_valid <= 1'b1;
            out_last       <= 1'b0;
            out_status     <= lpbu_pkg::ST_OK;
            out_size_known <= 1'b1;
            out_expected   <= length_word;
            out_written    <= emitted_next;
          end
        end
      end
    end
  end

  // payload count never runs past the decoded length
  assert property (@(posedge clk) disable iff (rst)
    length_ready |-> emitted <= length_word)
    else $error("payload count exceeds decoded length");

  // header counter stops at the header size
  assert property (@(posedge clk) disable iff (rst)
    hdr_seen <= 4'(lpbu_pkg::HEADER_BYTES))
    else $error("header byte counter overrun");

  // a payload byte is never a closing result and lies within the length
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_byte_valid |->
      !out_last && out_size_known && out_written != 64'd0 && out_written <= out_expected)
    else $error("bad payload result");

  // header-short status only while the header is incomplete
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status == lpbu_pkg::ST_HDR_SHORT |-> !out_size_known && out_last)
    else $error("header-short status with known size");

  // a byte step that completes the header sets the ready flag
  assert property (@(posedge clk) disable iff (rst)
    busy && !pop && can_step && !is_finish && !stream_done && fill_sum >= 8'd8 &&
      !length_ready && hdr_seen_next >= 4'(lpbu_pkg::HEADER_BYTES) |=> length_ready)
    else $error("header completion missed");

endmodule

// ===== design/length_prefixed_bit_unpacker.sv =====
// ----------------------------------------------------------------------------
// length_prefixed_bit_unpacker
// Packs bit fields MSB first into bytes, reads an 8-byte length header and
// streams out the payload bytes that follow.
// ----------------------------------------------------------------------------
// An item leaves the two-entry input queue into the back end, which steps
// through its completed bytes and then issues its closing result; the back
// end takes the next item only after that closing result. The output
// register holds its result whenever the result side stalls. Bytes that
// fill the header produce no result; once the decoded number of payload
// bytes is out, further bits are dropped. A finish item reports status 0 ok,
// 1 header incomplete or 2 length mismatch.
module length_prefixed_bit_unpacker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [71:0]  s_tdata,   // bit_value[63:0], bit_count[70:64], zero[71]
  input  logic         s_tuser,   // operation[0]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [143:0] m_tdata,   // out_byte[7:0], size_known[8],
                                  // expected_length[72:9], written_count[136:73],
                                  // zero[143:137]
  output logic [2:0]   m_tuser,   // byte_valid[0], status[2:1]
  output logic         m_tlast    // last
);

  lpbu_pkg::entry_t front_entry;
  lpbu_pkg::entry_t head_entry;
  logic             fifo_full;
  logic             head_valid;
  logic             pop;
  logic [7:0]       out_byte;
  logic             out_byte_valid;
  logic [1:0]       out_status;
  logic             out_size_known;
  logic [63:0]      out_expected;
  logic [63:0]      out_written;

  assign s_tready = !fifo_full;

  // classify incoming transactions
  lpbu_front u_front (
    .operation (s_tuser),
    .bit_value (s_tdata[63:0]),
    .bit_count (s_tdata[70:64]),
    .entry     (front_entry)
  );

  // queue between front and back
  lpbu_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (s_tvalid && s_tready),
    .push_entry (front_entry),
    .full       (fifo_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_entry (head_entry)
  );

  // byte engine with output register
  lpbu_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head_valid     (head_valid),
    .head_entry     (head_entry),
    .pop            (pop),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .out_last       (m_tlast),
    .out_status     (out_status),
    .out_size_known (out_size_known),
    .out_expected   (out_expected),
    .out_written    (out_written)
  );

  // pack result fields
  assign m_tdata = {7'd0, out_written, out_expected, out_size_known, out_byte};
  assign m_tuser = {out_status, out_byte_valid};

endmodule

// ===== tb/tb_length_prefixed_bit_unpacker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_length_prefixed_bit_unpacker
// Streams bit-field appends and finish requests into the unpacker and keeps a
// per-item model of the byte packer, length header and payload counter.
// Every result transaction is checked field by field against the model,
// with random idling on both sides, one long result-side hold-off and
// occasional pauses of the sender until all results are in.
// ----------------------------------------------------------------------------
module tb_length_prefixed_bit_unpacker;

  localparam int LIMIT_CYCLES = 400000;
  localparam int IDLE_MAX     = 18;
  localparam int HOLD_CYCLES  = 300;
  localparam int HOLD_AT_ITEM = 40;
  localparam int TAIL_CYCLES  = 24;

  typedef struct {
    logic        op;
    logic [63:0] value;
    logic [6:0]  count;
    bit          drain;
  } bit_item_t;

  typedef struct {
    logic [7:0]  data;
    logic        byte_valid;
    logic        last;
    logic [1:0]  status;
    logic        size_known;
    logic [63:0] length;
    logic [63:0] written;
  } unpack_result_t;

  logic         clk      = 1'b0;
  logic         rst      = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [71:0]  s_tdata  = '0;  // bit_value[63:0], bit_count[70:64], zero[71]
  logic         s_tuser  = 1'b0; // operation[0]
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [143:0] m_tdata;  // out_byte[7:0], size_known[8], expected_length[72:9],
                          // written_count[136:73], zero[143:137]
  logic [2:0]   m_tuser;  // byte_valid[0], status[2:1]
  logic         m_tlast;

  length_prefixed_bit_unpacker uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // pending stimulus and expected results
  bit_item_t      bit_items[$];
  unpack_result_t pending_results[$];
  longint         bits_queued = 0;

  // shadow state of the unpacker
  logic [6:0]  part_bits;
  logic [2:0]  part_count;
  int          hdr_count;
  logic [63:0] len_word;
  logic        len_known;
  logic [63:0] emitted;

  int errors       = 0;
  int cycles       = 0;
  int items_taken  = 0;
  int results_seen = 0;

  // handshake flags handed from the sampling edge to the driving edge
  logic in_taken  = 1'b0;
  logic out_taken = 1'b0;
  logic hold_req  = 1'b0;

  bit offering     = 1'b0;
  int gap_left     = 0;
  int stall_left   = 0;
  int hold_left    = 0;
  bit hold_started = 1'b0;

  // clock
  initial begin
    forever #10 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("** length_prefixed_bit_unpacker: FAILED **");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // random upper bits, given low bits
  function automatic logic [63:0] with_low(input logic [63:0] bits, input int k);
    logic [63:0] mask;
    mask = (k >= 64) ? '1 : ((64'd1 << k) - 64'd1);
    return (rand64() & ~mask) | (bits & mask);
  endfunction

  function automatic int idle_draw(input bit quiet);
    return quiet ? 0 : $urandom_range(0, IDLE_MAX);
  endfunction

  function automatic bit stream_complete();
    return len_known && (emitted >= len_word);
  endfunction

  task automatic add_item(input logic op, input logic [63:0] value,
                          input logic [6:0] count, input bit drain);
    bit_item_t it;
    it = '{op, value, count, drain};
    bit_items.insert(bit_items.size(), it);
    if (op == lpbu_pkg::OP_APPEND)
      bits_queued += (count > lpbu_pkg::MAX_BITS) ? 64 : count;
  endtask

  task automatic push_result(input logic [7:0] data, input logic byte_valid,
                             input logic last, input logic [1:0] status);
    unpack_result_t res;
    res = '{data, byte_valid, last, status, len_known, len_word, emitted};
    pending_results.insert(pending_results.size(), res);
  endtask

  // a completed byte goes into the header, then the payload, then nowhere
  task automatic absorb_byte(input logic [7:0] b);
    if (!len_known) begin
      len_word = {len_word[55:0], b};
      hdr_count++;
      if (hdr_count >= lpbu_pkg::HEADER_BYTES)
        len_known = 1'b1;
    end else if (emitted < len_word) begin
      emitted++;
      push_result(b, 1'b1, 1'b0, lpbu_pkg::ST_OK);
    end
  endtask

  // expected results of one input transaction
  task automatic unpack_item(input logic op, input logic [63:0] value,
                             input logic [6:0] count);
    int          n;
    logic [7:0]  cur;
    logic [1:0]  st;
    if (op == lpbu_pkg::OP_FINISH) begin
      if (!len_known)
        st = lpbu_pkg::ST_HDR_SHORT;
      else if (emitted != len_word)
        st = lpbu_pkg::ST_MISMATCH;
      else
        st = lpbu_pkg::ST_OK;
      push_result(8'd0, 1'b0, 1'b1, st);
      return;
    end
    n = (count > lpbu_pkg::MAX_BITS) ? 64 : count;
    if (!stream_complete()) begin
      for (int i = n - 1; i >= 0; i--) begin
        cur = {part_bits, value[i]};
        if (part_count == 3'd7) begin
          part_bits  = '0;
          part_count = '0;
          absorb_byte(cur);
          if (stream_complete())
            break;
        end else begin
          part_bits  = cur[6:0];
          part_count = part_count + 3'd1;
        end
      end
    end
    push_result(8'd0, 1'b0, 1'b1, lpbu_pkg::ST_OK);
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      errors++;
    end
  endtask

  // sample both handshakes, predict on input, check on output
  always @(posedge clk) begin
    unpack_result_t got;
    unpack_result_t want;
    if (rst) begin
      part_bits  = '0;
      part_count = '0;
      hdr_count  = 0;
      len_word   = '0;
      len_known  = 1'b0;
      emitted    = '0;
      in_taken  <= 1'b0;
      out_taken <= 1'b0;
    end else begin
      in_taken  <= s_tvalid && s_tready;
      out_taken <= m_tvalid && m_tready;
      if (s_tvalid && s_tready) begin
        unpack_item(s_tuser, s_tdata[63:0], s_tdata[70:64]);
        items_taken++;
        if (items_taken == HOLD_AT_ITEM)
          hold_req <= 1'b1;
      end
      if (m_tvalid && m_tready) begin
        got = '{m_tdata[7:0], m_tuser[0], m_tlast, m_tuser[2:1], m_tdata[8],
                m_tdata[72:9], m_tdata[136:73]};
        results_seen++;
        if (pending_results.size() == 0) begin
          $error("result transaction with nothing expected");
          errors++;
        end else begin
          want = pending_results.pop_front();
          check_field("out_byte", want.data, got.data);
          check_field("byte_valid", want.byte_valid, got.byte_valid);
          check_field("last", want.last, got.last);
          check_field("status", want.status, got.status);
          check_field("size_known", want.size_known, got.size_known);
          check_field("expected_length", want.length, got.length);
          check_field("written_count", want.written, got.written);
        end
      end
    end
  end

  // input driver, fed from the item queue
  always @(negedge clk) begin
    bit_item_t it;
    if (!rst) begin
      if (in_taken) begin
        offering = 1'b0;
        gap_left = idle_draw((items_taken / 32) % 4 == 3);
      end
      if (!offering) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (bit_items.size() != 0 &&
                     (!bit_items[0].drain || pending_results.size() == 0)) begin
          it = bit_items.pop_front();
          offering = 1'b1;
          s_tdata <= {1'b0, it.count, it.value};
          s_tuser <= it.op;
        end
      end
      s_tvalid <= offering;
    end
  end

  // result receiver with per-transaction stalls and one long hold-off
  always @(negedge clk) begin
    if (!rst) begin
      if (hold_req && !hold_started) begin
        hold_left    = HOLD_CYCLES;
        hold_started = 1'b1;
      end
      if (out_taken)
        stall_left = idle_draw((results_seen / 40) % 4 == 1);
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // stimulus and end of run
  initial begin
    logic [63:0] hdr;
    int          len;
    longint      need_bits;
    int          extra;
    int          n_rand;
    int          r;
    logic [6:0]  cnt;

    len       = $urandom_range(1100, 1300);
    hdr       = 64'(len);
    need_bits = 8 * (lpbu_pkg::HEADER_BYTES + len);

    // header built up in pieces, with finishes in between
    add_item(lpbu_pkg::OP_FINISH, rand64(), 7'($urandom_range(0, 127)), 1'b0);
    add_item(lpbu_pkg::OP_APPEND, '1, 7'd0, 1'b0);
    add_item(lpbu_pkg::OP_APPEND, with_low(hdr[63:61], 3), 7'd3, 1'b0);
    add_item(lpbu_pkg::OP_FINISH, rand64(), 7'd64, 1'b0);
    add_item(lpbu_pkg::OP_APPEND, with_low(hdr[60:56], 5), 7'd5, 1'b0);
    add_item(lpbu_pkg::OP_APPEND, with_low(hdr[55:16], 40), 7'd40, 1'b0);
    add_item(lpbu_pkg::OP_FINISH, '1, 7'd127, 1'b0);
    add_item(lpbu_pkg::OP_APPEND, with_low(hdr[15:0], 16), 7'd16, 1'b0);
    add_item(lpbu_pkg::OP_FINISH, rand64(), 7'd0, 1'b1);

    // full-width, oversized, single-bit and 63-bit appends into the payload, then a finish
    add_item(lpbu_pkg::OP_APPEND, '1, 7'd64, 1'b0);
    add_item(lpbu_pkg::OP_APPEND, '0, 7'd64, 1'b0);
    add_item(lpbu_pkg::OP_APPEND, rand64(), 7'd127, 1'b0);
    add_item(lpbu_pkg::OP_APPEND, rand64(), 7'd65, 1'b0);
    add_item(lpbu_pkg::OP_APPEND, rand64(), 7'd100, 1'b0);
    for (int i = 0; i < 8; i++)
      add_item(lpbu_pkg::OP_APPEND, rand64(), 7'd1, 1'b0);
    add_item(lpbu_pkg::OP_APPEND, rand64(), 7'd63, 1'b0);
    add_item(lpbu_pkg::OP_FINISH, rand64(), 7'd8, 1'b0);

    // random payload until the stream completes, then a little more
    extra  = 0;
    n_rand = 0;
    while ((bits_queued < need_bits || extra < 25) && n_rand < 520) begin
      if (bits_queued >= need_bits)
        extra++;
      n_rand++;
      r = $urandom_range(0, 99);
      if (r < 15)
        cnt = 7'($urandom_range(1, 8));
      else if (r < 25)
        cnt = lpbu_pkg::MAX_BITS;
      else if (r < 30)
        cnt = 7'($urandom_range(65, 127));
      else if (r < 33)
        cnt = 7'd0;
      else
        cnt = 7'($urandom_range(1, 63));
      add_item((r < 5) ? lpbu_pkg::OP_FINISH : lpbu_pkg::OP_APPEND, rand64(), cnt,
               $urandom_range(0, 49) == 0);
    end

    // completed stream: finish ok, appends ignored
    add_item(lpbu_pkg::OP_FINISH, rand64(), 7'd127, 1'b1);
    add_item(lpbu_pkg::OP_APPEND, '1, 7'd64, 1'b0);
    add_item(lpbu_pkg::OP_FINISH, '0, 7'd0, 1'b0);

    // reset
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // wait for all transactions in and out
    while (bit_items.size() != 0 || s_tvalid)
      @(posedge clk);
    while (pending_results.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (errors == 0 && pending_results.size() == 0)
      $display("** length_prefixed_bit_unpacker: PASSED **");
    else
      $display("** length_prefixed_bit_unpacker: FAILED **");
    $finish;
  end

endmodule
